// File: hw/rtl/olist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_pkg
// shared constants, codes and controller/datapath types for the list engine
// ----------------------------------------------------------------------------
package olist_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMD_W    = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int ST_W     = 3;
    localparam int FIDX_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int EP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_INS_AT   = 3'd2,
        CMD_REM_HEAD = 3'd3,
        CMD_REM_TAIL = 3'd4,
        CMD_REM_AT   = 3'd5,
        CMD_SEARCH   = 3'd6,
        CMD_READ     = 3'd7
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_INS,
        KIND_REM,
        KIND_SRCH,
        KIND_READ
    } kind_t;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DN_FIRST,
        STEP_DN,
        STEP_SRCH
    } step_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SHIFT,
        S_REM_ISSUE,
        S_REM_CAP,
        S_REM_SHIFT,
        S_RD_ISSUE,
        S_RD_CAP,
        S_SRCH,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic  load;
        logic  decode;
        step_t step;
        logic  write_val;
        logic  capture;
        logic  capture_hit;
        logic  finish;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  proceed;
        logic  up_done;
        logic  dn_done;
        logic  hit;
        logic  srch_end;
        logic  out_free;
    } dp_stat_t;

endpackage

// File: hw/rtl/olist_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_req_if
// command channel: valid/ready with command, value and position
// ----------------------------------------------------------------------------
interface olist_req_if;
    import olist_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, output command, output value, output position,
                    input ready);
    modport sink (input valid, input command, input value, input position,
                  output ready);
endinterface

// File: hw/rtl/olist_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_rsp_if
// result channel: valid/ready with status, data, index, count and empty flag
// ----------------------------------------------------------------------------
interface olist_rsp_if;
    import olist_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] data;
    logic [FIDX_W-1:0]       found_index;
    logic [COUNT_W-1:0]      count;
    logic                    is_empty;

    modport source (output valid, output status, output data, output found_index,
                    output count, output is_empty, input ready);
    modport sink (input valid, input status, input data, input found_index,
                  input count, input is_empty, output ready);
endinterface

// File: hw/rtl/olist_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_ctrl
// command sequencer: decodes, walks the element store and hands off results
// ----------------------------------------------------------------------------
module olist_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  olist_pkg::dp_stat_t   stat,
    output olist_pkg::ctrl_cmd_t  ctl
);
    import olist_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.proceed)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    case (stat.kind)
                        KIND_INS:  state_next = S_INS_SHIFT;
                        KIND_REM:  state_next = S_REM_ISSUE;
                        KIND_SRCH: state_next = S_SRCH;
                        KIND_READ: state_next = S_RD_ISSUE;
                        default:   state_next = S_FINISH;
                    endcase
                end
            end
            S_INS_SHIFT:
            begin
                if (stat.up_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_REM_ISSUE: state_next = S_REM_CAP;
            S_REM_CAP:   state_next = S_REM_SHIFT;
            S_REM_SHIFT:
            begin
                if (stat.dn_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_RD_ISSUE:  state_next = S_RD_CAP;
            S_RD_CAP:    state_next = S_FINISH;
            S_SRCH:
            begin
                if (stat.hit || stat.srch_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready       = 1'b0;
        ctl             = '0;
        ctl.step        = STEP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                ctl.load  = req_valid;
            end
            S_DECODE:
            begin
                ctl.decode = 1'b1;
            end
            S_INS_SHIFT:
            begin
                if (stat.up_done)
                begin
                    ctl.write_val = 1'b1;
                end
                else
                begin
                    ctl.step = STEP_UP;
                end
            end
            S_REM_ISSUE:
            begin
                ctl.step = STEP_DN_FIRST;
            end
            S_REM_CAP:
            begin
                ctl.capture = 1'b1;
                ctl.step    = STEP_DN;
            end
            S_REM_SHIFT:
            begin
                if (!stat.dn_done)
                begin
                    ctl.step = STEP_DN;
                end
            end
            S_RD_ISSUE:
            begin
                ctl.step = STEP_DN_FIRST;
            end
            S_RD_CAP:
            begin
                ctl.capture = 1'b1;
            end
            S_SRCH:
            begin
                if (stat.hit)
                begin
                    ctl.capture_hit = 1'b1;
                end
                else if (!stat.srch_end)
                begin
                    ctl.step = STEP_SRCH;
                end
            end
            S_FINISH:
            begin
                ctl.finish = stat.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/olist_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_dp
// element store, walk pointer, move pipeline and result register
// ----------------------------------------------------------------------------
module olist_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [olist_pkg::CMD_W-1:0]        command,
    input  logic signed [olist_pkg::VAL_W-1:0] value,
    input  logic [olist_pkg::POS_W-1:0]        position,
    input  olist_pkg::ctrl_cmd_t    ctl,
    output olist_pkg::dp_stat_t     stat,
    olist_rsp_if.source             result
);
    import olist_pkg::*;

    logic signed [VAL_W-1:0] store_mem [CAPACITY];

    cmd_t                    cmd_reg;
    cmd_t                    cmd_next;
    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        pos_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        ptr_reg;
    logic [CNT_W-1:0]        ptr_next;
    logic [CNT_W-1:0]        tgt_reg;
    logic [CNT_W-1:0]        tgt_next;
    logic                    pend_reg;
    logic                    pend_next;
    logic                    pend_wr_reg;
    logic                    pend_wr_next;
    logic [IDX_W-1:0]        pend_addr_reg;
    logic [IDX_W-1:0]        pend_addr_next;
    logic signed [VAL_W-1:0] rdata_reg;
    status_t                 status_reg;
    status_t                 status_next;
    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    status_t                 out_status_reg;
    status_t                 out_status_next;
    logic signed [VAL_W-1:0] out_data_reg;
    logic signed [VAL_W-1:0] out_data_next;
    logic [IDX_W-1:0]        out_idx_reg;
    logic [IDX_W-1:0]        out_idx_next;
    logic [CNT_W-1:0]        out_count_reg;
    logic [CNT_W-1:0]        out_count_next;
    logic                    out_empty_reg;
    logic                    out_empty_next;

    kind_t                   kind;
    logic [EP_W-1:0]         eff_pos;
    logic [EP_W-1:0]         cnt_ep;
    status_t                 dec_status;
    logic [CNT_W-1:0]        ptr_m1;
    logic [CNT_W-1:0]        ptr_p1;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    // command decode and checks
    always_comb
    begin
        cnt_ep  = EP_W'(count_reg);
        kind    = KIND_READ;
        eff_pos = EP_W'(pos_reg);
        case (cmd_reg)
            CMD_INS_HEAD:
            begin
                kind    = KIND_INS;
                eff_pos = '0;
            end
            CMD_INS_TAIL:
            begin
                kind    = KIND_INS;
                eff_pos = cnt_ep;
            end
            CMD_INS_AT:   kind = KIND_INS;
            CMD_REM_HEAD:
            begin
                kind    = KIND_REM;
                eff_pos = '0;
            end
            CMD_REM_TAIL:
            begin
                kind    = KIND_REM;
                eff_pos = cnt_ep - EP_W'(1);
            end
            CMD_REM_AT:   kind = KIND_REM;
            CMD_SEARCH:   kind = KIND_SRCH;
            CMD_READ:     kind = KIND_READ;
            default:      kind = KIND_READ;
        endcase

        dec_status = ST_OK;
        case (kind)
            KIND_INS:
            begin
                if (eff_pos > cnt_ep)
                begin
                    dec_status = ST_BADPOS;
                end
                else if (count_reg >= CNT_W'(CAPACITY))
                begin
                    dec_status = ST_FULL;
                end
            end
            KIND_SRCH:
            begin
                dec_status = ST_NOTFOUND;
            end
            default:
            begin
                if (count_reg == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (eff_pos >= cnt_ep)
                begin
                    dec_status = ST_BADPOS;
                end
            end
        endcase
    end

    assign ptr_m1 = ptr_reg - CNT_W'(1);
    assign ptr_p1 = ptr_reg + CNT_W'(1);

    assign stat.kind     = kind;
    assign stat.proceed  = (dec_status == ST_OK) || (kind == KIND_SRCH);
    assign stat.up_done  = (ptr_reg == tgt_reg) && !pend_reg;
    assign stat.dn_done  = (ptr_reg >= count_reg) && !pend_wr_reg;
    assign stat.hit      = pend_reg && !pend_wr_reg && (rdata_reg == val_reg);
    assign stat.srch_end = (ptr_reg >= count_reg) && !pend_reg;
    assign stat.out_free = !out_valid_reg || result.ready;

    // store write port: pending move first, else the inserted value
    assign wr_en   = pend_wr_reg || ctl.write_val;
    assign wr_addr = pend_wr_reg ? pend_addr_reg : tgt_reg[IDX_W-1:0];
    assign wr_data = pend_wr_reg ? rdata_reg : val_reg;

    always_comb
    begin
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        tgt_next        = tgt_reg;
        pend_next       = 1'b0;
        pend_wr_next    = 1'b0;
        pend_addr_next  = pend_addr_reg;
        status_next     = status_reg;
        data_next       = data_reg;
        idx_next        = idx_reg;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg[IDX_W-1:0];
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_idx_next    = out_idx_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;

        if (ctl.load)
        begin
            cmd_next = cmd_t'(command);
            val_next = value;
            pos_next = position;
        end

        if (ctl.decode)
        begin
            status_next = dec_status;
            data_next   = '0;
            idx_next    = '0;
            tgt_next    = CNT_W'(eff_pos);
            case (kind)
                KIND_INS:  ptr_next = count_reg;
                KIND_SRCH: ptr_next = '0;
                default:   ptr_next = CNT_W'(eff_pos);
            endcase
        end

        case (ctl.step)
            STEP_UP:
            begin
                if (ptr_reg > tgt_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = ptr_m1[IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_wr_next   = 1'b1;
                    pend_addr_next = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_m1;
                end
            end
            STEP_DN_FIRST:
            begin
                rd_en     = 1'b1;
                pend_next = 1'b1;
                ptr_next  = ptr_p1;
            end
            STEP_DN:
            begin
                if (ptr_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_wr_next   = 1'b1;
                    pend_addr_next = ptr_m1[IDX_W-1:0];
                    ptr_next       = ptr_p1;
                end
            end
            STEP_SRCH:
            begin
                if (ptr_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_p1;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase

        if (ctl.capture)
        begin
            data_next = rdata_reg;
        end

        if (ctl.capture_hit)
        begin
            status_next = ST_OK;
            data_next   = val_reg;
            idx_next    = pend_addr_reg;
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ctl.finish)
        begin
            if ((status_reg == ST_OK) && (kind == KIND_INS))
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if ((status_reg == ST_OK) && (kind == KIND_REM))
            begin
                count_next = count_reg - CNT_W'(1);
            end
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_data_next   = data_reg;
            out_idx_next    = idx_reg;
            out_count_next  = count_next;
            out_empty_next  = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_wr_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            pend_wr_reg   <= pend_wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        ptr_reg        <= ptr_next;
        tgt_reg        <= tgt_next;
        pend_addr_reg  <= pend_addr_next;
        status_reg     <= status_next;
        data_reg       <= data_next;
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_idx_reg    <= out_idx_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
    end

    // element store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = ST_W'(out_status_reg);
    assign result.data        = out_data_reg;
    assign result.found_index = FIDX_W'(out_idx_reg);
    assign result.count       = COUNT_W'(out_count_reg);
    assign result.is_empty    = out_empty_reg;

    a_finish_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> out_valid_reg)
        else $error("result register not loaded after finish");

    a_finish_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> (!out_valid_reg || result.ready))
        else $error("finish while result register still occupied");

    a_single_write_port: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.write_val |-> !pend_wr_reg)
        else $error("value write collides with a pending move");

    a_count_changes_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.finish |=> $stable(count_reg))
        else $error("element count changed outside finish");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> (count_reg <= CNT_W'(CAPACITY)) && (out_count_reg == count_reg))
        else $error("element count out of range or not reported");

endmodule

// File: hw/rtl/ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// ordered list of up to CAPACITY signed 32-bit values, one command per transfer
// ----------------------------------------------------------------------------
// usage:
//   request carries command, value and position; result carries status, data,
//   found_index, count and is_empty, one result transfer per request transfer
//   one command is worked at a time; request.ready is high only while idle
//   a command that passes its checks is worked as follows: a read fetches
//   one element; an insert moves each element at or after the position up
//   by one, then writes the value; a remove reads the element, then moves
//   each element after it down by one; a search compares elements from the
//   head until a hit or the end of the list
//   the engine returns to idle on the clock edge that raises result.valid;
//   one element is moved or compared per cycle through one read and one
//   write port on the element store, with the read data registered
//   the result sits in an output register, so the next request is taken while
//   an earlier result is still waiting; a stalled result only holds the
//   engine once the following command has finished
//   reset empties the list; store entries are not cleared and are only read
//   below the element count
// ----------------------------------------------------------------------------
module ordered_list_engine (
    input  logic          clk,
    input  logic          rst_n,
    olist_req_if.sink     request,
    olist_rsp_if.source   result
);
    import olist_pkg::*;

    ctrl_cmd_t ctl;
    dp_stat_t  stat;

    olist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    olist_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .command  (request.command),
        .value    (request.value),
        .position (request.position),
        .ctl      (ctl),
        .stat     (stat),
        .result   (result)
    );

endmodule

// File: sim/tb_ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine
// self-checking bench for the ordered list engine: a directed table of list
// corner cases, then fill/drain/mixed random phases, each result compared
// field by field against the table or a shadow copy of the list, with bursty
// requests and a patterned result stall
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;
    import olist_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 2 * CAPACITY + 10;
    localparam int PRINT_LIMIT  = 100;

    typedef struct {
        status_t                 status;
        logic signed [VAL_W-1:0] data;
        logic [FIDX_W-1:0]       found_index;
        logic [COUNT_W-1:0]      count;
        logic                    is_empty;
    } list_rsp_t;

    typedef struct {
        cmd_t                    command;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
        bit                      known;
        status_t                 status;
        logic signed [VAL_W-1:0] data;
        logic [COUNT_W-1:0]      count;
    } directed_row_t;

    typedef enum int {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } mix_t;

    typedef enum int {
        RX_STEADY,
        RX_RANDOM,
        RX_PATTERN,
        RX_BLOCKY
    } rx_mode_t;

    localparam int DIRECTED_ROWS = 25;

    directed_row_t directed [DIRECTED_ROWS] = '{
        '{CMD_REM_HEAD, 32'sd0,            5'd0,  1'b1, ST_EMPTY,    32'sd0,            5'd0},
        '{CMD_REM_TAIL, 32'sd0,            5'd0,  1'b1, ST_EMPTY,    32'sd0,            5'd0},
        '{CMD_REM_AT,   32'sd0,            5'd0,  1'b1, ST_EMPTY,    32'sd0,            5'd0},
        '{CMD_READ,     32'sd0,            5'd31, 1'b1, ST_EMPTY,    32'sd0,            5'd0},
        '{CMD_SEARCH,   32'sd0,            5'd0,  1'b1, ST_NOTFOUND, 32'sd0,            5'd0},
        '{CMD_INS_AT,   32'sd5,            5'd1,  1'b1, ST_BADPOS,   32'sd0,            5'd0},
        '{CMD_INS_AT,   32'sd5,            5'd31, 1'b1, ST_BADPOS,   32'sd0,            5'd0},
        '{CMD_INS_HEAD, 32'sh7fffffff,     5'd9,  1'b1, ST_OK,       32'sd0,            5'd1},
        '{CMD_INS_TAIL, 32'sh80000000,     5'd17, 1'b1, ST_OK,       32'sd0,            5'd2},
        '{CMD_INS_AT,   -32'sd1,           5'd2,  1'b1, ST_OK,       32'sd0,            5'd3},
        '{CMD_INS_AT,   32'sh5a5a5a5a,     5'd1,  1'b0, ST_OK,       32'sd0,            5'd0},
        '{CMD_INS_AT,   32'sd0,            5'd0,  1'b0, ST_OK,       32'sd0,            5'd0},
        '{CMD_READ,     32'sd0,            5'd31, 1'b1, ST_BADPOS,   32'sd0,            5'd5},
        '{CMD_READ,     32'sd0,            5'd5,  1'b1, ST_BADPOS,   32'sd0,            5'd5},
        '{CMD_REM_AT,   32'sd0,            5'd5,  1'b1, ST_BADPOS,   32'sd0,            5'd5},
        '{CMD_READ,     32'sd0,            5'd0,  1'b0, ST_OK,       32'sd0,            5'd0},
        '{CMD_READ,     32'sd0,            5'd4,  1'b0, ST_OK,       32'sd0,            5'd0},
        '{CMD_SEARCH,   32'sh80000000,     5'd0,  1'b0, ST_OK,       32'sd0,            5'd0},
        '{CMD_SEARCH,   -32'sd1,           5'd0,  1'b0, ST_OK,       32'sd0,            5'd0},
        '{CMD_SEARCH,   32'sd12345,        5'd0,  1'b1, ST_NOTFOUND, 32'sd0,            5'd5},
        '{CMD_INS_AT,   32'sd7,            5'd6,  1'b1, ST_BADPOS,   32'sd0,            5'd5},
        '{CMD_REM_TAIL, 32'sd0,            5'd0,  1'b0, ST_OK,       32'sd0,            5'd0},
        '{CMD_REM_HEAD, 32'sd0,            5'd0,  1'b0, ST_OK,       32'sd0,            5'd0},
        '{CMD_REM_AT,   32'sd0,            5'd1,  1'b0, ST_OK,       32'sd0,            5'd0},
        '{CMD_INS_HEAD, 32'sd0,            5'd0,  1'b0, ST_OK,       32'sd0,            5'd0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic rx_ready = 1'b0;
    logic [15:0] rx_tick = '0;
    rx_mode_t rx_mode = RX_STEADY;

    logic signed [VAL_W-1:0] shadow_list [CAPACITY];
    int                      shadow_count = 0;
    list_rsp_t               expected_results [$];
    list_rsp_t               head_result;
    int                      burst_left = 0;
    int                      mismatches = 0;
    int                      results_seen = 0;

    olist_req_if cmd_ch ();
    olist_rsp_if rsp_ch ();

    ordered_list_engine DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (cmd_ch),
        .result  (rsp_ch)
    );

    assign rsp_ch.ready = rx_ready;

    always #HALF_PERIOD clk = ~clk;

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("%0t mismatch, result %0d: %s", $time, results_seen, what);
        mismatches++;
    endtask

    function automatic list_rsp_t apply_list_command(input cmd_t c,
                                                     input logic signed [VAL_W-1:0] v,
                                                     input logic [POS_W-1:0] p);
        list_rsp_t r;
        int        at;
        int        i;
        r.status      = ST_OK;
        r.data        = '0;
        r.found_index = '0;
        at            = p;
        case (c)
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT:
            begin
                if (c == CMD_INS_HEAD)
                    at = 0;
                else if (c == CMD_INS_TAIL)
                    at = shadow_count;
                if (at > shadow_count)
                    r.status = ST_BADPOS;
                else if (shadow_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = shadow_count; i > at; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[at] = v;
                    shadow_count++;
                end
            end
            CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_AT:
            begin
                if (c == CMD_REM_HEAD)
                    at = 0;
                else if (c == CMD_REM_TAIL)
                    at = shadow_count - 1;
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else if (at >= shadow_count)
                    r.status = ST_BADPOS;
                else
                begin
                    r.data = shadow_list[at];
                    for (i = at; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                end
            end
            CMD_SEARCH:
            begin
                r.status = ST_NOTFOUND;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (r.status == ST_NOTFOUND && shadow_list[i] == v)
                    begin
                        r.status      = ST_OK;
                        r.data        = v;
                        r.found_index = FIDX_W'(i);
                    end
                end
            end
            default:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else if (at >= shadow_count)
                    r.status = ST_BADPOS;
                else
                    r.data = shadow_list[at];
            end
        endcase
        r.count    = COUNT_W'(shadow_count);
        r.is_empty = (shadow_count == 0);
        return r;
    endfunction

    task automatic issue(input cmd_t c, input logic signed [VAL_W-1:0] v,
                         input logic [POS_W-1:0] p, input bit use_known,
                         input list_rsp_t known_rsp);
        list_rsp_t predicted;
        int        gap;
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= c;
        cmd_ch.value    <= v;
        cmd_ch.position <= p;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predicted = apply_list_command(c, v, p);
        if (use_known)
            expected_results.push_back(known_rsp);
        else
            expected_results.push_back(predicted);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // result stall pattern
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 16'd1;
        if (rx_tick % 97 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_STEADY:  rx_ready <= 1'b1;
            RX_RANDOM:  rx_ready <= ($urandom_range(0, 2) != 0);
            RX_PATTERN: rx_ready <= (rx_tick[2:0] != 3'd5) && (rx_tick[2:0] != 3'd6);
            default:    rx_ready <= rx_tick[4];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
                flag_mismatch("result transfer with nothing expected");
            else
            begin
                head_result = expected_results.pop_front();
                if (rsp_ch.status !== head_result.status)
                    flag_mismatch($sformatf("status got %0d want %s",
                                            rsp_ch.status, head_result.status.name()));
                if (rsp_ch.data !== head_result.data)
                    flag_mismatch($sformatf("data got %0d want %0d",
                                            rsp_ch.data, head_result.data));
                if (rsp_ch.found_index !== head_result.found_index)
                    flag_mismatch($sformatf("found_index got %0d want %0d",
                                            rsp_ch.found_index, head_result.found_index));
                if (rsp_ch.count !== head_result.count)
                    flag_mismatch($sformatf("count got %0d want %0d",
                                            rsp_ch.count, head_result.count));
                if (rsp_ch.is_empty !== head_result.is_empty)
                    flag_mismatch($sformatf("is_empty got %0b want %0b",
                                            rsp_ch.is_empty, head_result.is_empty));
            end
            results_seen++;
        end
    end

    initial
    begin
        list_rsp_t               known_rsp;
        cmd_t                    c;
        logic signed [VAL_W-1:0] v;
        logic [POS_W-1:0]        p;
        mix_t                    mix;
        int                      pick;
        int                      ins_share;
        int                      rem_share;
        int                      phase_left;
        int                      phase_no;
        int                      small_val;
        int                      n;
        int                      waited;

        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = CMD_INS_HEAD;
        cmd_ch.value    = '0;
        cmd_ch.position = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < DIRECTED_ROWS; n++)
        begin
            known_rsp.status      = directed[n].status;
            known_rsp.data        = directed[n].data;
            known_rsp.found_index = '0;
            known_rsp.count       = directed[n].count;
            known_rsp.is_empty    = (directed[n].count == 0);
            issue(directed[n].command, directed[n].value, directed[n].position,
                  directed[n].known, known_rsp);
        end

        // fill, balanced, drain, balanced phases so the list hits full and empty
        phase_left = 0;
        phase_no   = 0;
        mix        = MIX_FILL;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                case (phase_no % 4)
                    0:       mix = MIX_FILL;
                    2:       mix = MIX_DRAIN;
                    default: mix = MIX_BALANCED;
                endcase
                phase_no++;
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;

            ins_share = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 15 : 35;
            rem_share = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 55 : 35;
            pick = $urandom_range(0, 99);
            if (pick < ins_share)
                c = cmd_t'($urandom_range(0, 2));
            else if (pick < ins_share + rem_share)
                c = cmd_t'($urandom_range(3, 5));
            else
                c = cmd_t'($urandom_range(6, 7));

            pick = $urandom_range(0, 9);
            if (pick < 4)
                v = $urandom;
            else if (pick < 6)
            begin
                small_val = $urandom_range(0, 4);
                v = small_val - 2;
            end
            else if (pick < 9 && shadow_count > 0)
                v = shadow_list[$urandom_range(0, shadow_count - 1)];
            else
                v = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;

            if ($urandom_range(0, 3) != 0)
                p = POS_W'($urandom_range(0, shadow_count));
            else
                p = POS_W'($urandom_range(0, 31));

            issue(c, v, p, 1'b0, known_rsp);
        end
        cmd_ch.valid <= 1'b0;

        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        if (expected_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
